// ===== src/rep_pkg.sv =====
`default_nettype none

package rep_pkg;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_POSITION     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_POSITION     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_STEP_SIZE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_ENABLE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_TIMEOUT_MS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_WINDOW_MS   = 3'd6;
   localparam int unsigned CSR_DATA_W = 32;

   // Request kinds (carried on req_tuser)
   localparam logic REQ_CHAN_A_EVENT = 1'b0;
   localparam logic REQ_LOAD         = 1'b1;

   // Field widths
   localparam int unsigned POS_W  = 16;
   localparam int unsigned STEP_W = 8;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned SUM_W  = POS_W + 2;

   localparam int unsigned REQ_TDATA_W = 56;
   localparam int unsigned RSP_TDATA_W = 24;

   // Reset values of the configuration registers
   localparam logic signed [POS_W-1:0] MIN_POSITION_RST   = -16'sd32767;
   localparam logic signed [POS_W-1:0] MAX_POSITION_RST   = 16'sd32766;
   localparam logic [STEP_W-1:0]       STEP_SIZE_RST      = 8'd1;
   localparam logic [STEP_W-1:0]       FAST_STEP_SIZE_RST = 8'd1;
   localparam logic [TIME_W-1:0]       PRESS_TIMEOUT_RST  = 32'd50;
   localparam logic [TIME_W-1:0]       FAST_WINDOW_RST    = 32'd100;

   // One request after unpacking
   typedef struct packed {
      logic                     req_type;
      logic                     chan_a;
      logic                     chan_b;
      logic [TIME_W-1:0]        now_ms;
      logic signed [POS_W-1:0]  load_value;
   } req_type_type;

   // One result
   typedef struct packed {
      logic signed [POS_W-1:0]  position;
      logic                     load_accepted;
      logic                     moved;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/rotary_encoder_position_core.sv =====
`default_nettype none

// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------
// req_     | in        | tuser: req_type; tdata: chan_a, chan_b, now_ms,
//          |           |        load_value
// rsp_     | out       | tdata: position, load_accepted, moved
// csr_     | in        | write enable, register index, write data
//
// A request is held in the request register, then passes the
// step/clamp logic into the response register, which holds the
// response until it is taken on rsp_.
// A new request is accepted every cycle while rsp_ does not stall.
// Reset is synchronous; it clears the press state, the position and the
// configuration to its defaults. A stall on rsp_ holds the response and
// the request register; req_tready drops only when both are full and
// rsp_tready is low.

module rotary_encoder_position_core (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire                              req_tuser,   // [0] req_type
   // [0] chan_a, [1] chan_b, [33:2] now_ms, [49:34] load_value, [55:50] zero
   input  wire  [rep_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response channel
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [15:0] position, [16] load_accepted, [17] moved, [23:18] zero
   output logic [rep_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // configuration writes
   input  wire                              csr_we,
   input  wire  [rep_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [rep_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rep_pkg::*;

   // Configuration registers
   logic signed [POS_W-1:0]  min_position_ff;
   logic signed [POS_W-1:0]  max_position_ff;
   logic [STEP_W-1:0]        step_size_ff;
   logic [STEP_W-1:0]        fast_step_size_ff;
   logic                     wrap_enable_ff;
   logic [TIME_W-1:0]        press_timeout_ff;
   logic [TIME_W-1:0]        fast_window_ff;

   // Encoder state
   logic                     press_open_ff, press_open_in;
   logic [TIME_W-1:0]        press_start_ff, press_start_in;
   logic                     captured_b_ff, captured_b_in;
   logic [TIME_W-1:0]        last_step_ff, last_step_in;
   logic signed [POS_W-1:0]  position_ff, position_in;

   // Pipeline registers
   logic                     req_valid_ff;
   req_type_type             req_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;

   logic                     advance;
   req_type_type             req_unpacked;

   // Working values
   logic [TIME_W-1:0]        press_elapsed;
   logic [TIME_W-1:0]        step_elapsed;
   logic [STEP_W-1:0]        inc;
   logic signed [SUM_W-1:0]  pos_ext, inc_ext, sum, lmin_ext, lmax_ext, upper_fix, lower_fix;
   logic signed [SUM_W-1:0]  load_ext;
   logic                     load_in_range;

   // Handshake: request register moves on when the response slot is free
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-POS_W-2){1'b0}}, rsp_ff.moved, rsp_ff.load_accepted,
                        rsp_ff.position};

   assign req_unpacked.req_type   = req_tuser;
   assign req_unpacked.chan_a     = req_tdata[0];
   assign req_unpacked.chan_b     = req_tdata[1];
   assign req_unpacked.now_ms     = req_tdata[33:2];
   assign req_unpacked.load_value = req_tdata[49:34];

   // Configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         min_position_ff   <= MIN_POSITION_RST;
         max_position_ff   <= MAX_POSITION_RST;
         step_size_ff      <= STEP_SIZE_RST;
         fast_step_size_ff <= FAST_STEP_SIZE_RST;
         wrap_enable_ff    <= 1'b0;
         press_timeout_ff  <= PRESS_TIMEOUT_RST;
         fast_window_ff    <= FAST_WINDOW_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_POSITION:     min_position_ff   <= csr_wdata[POS_W-1:0];
            CSR_MAX_POSITION:     max_position_ff   <= csr_wdata[POS_W-1:0];
            CSR_STEP_SIZE:        step_size_ff      <= csr_wdata[STEP_W-1:0];
            CSR_FAST_STEP_SIZE:   fast_step_size_ff <= csr_wdata[STEP_W-1:0];
            CSR_WRAP_ENABLE:      wrap_enable_ff    <= csr_wdata[0];
            CSR_PRESS_TIMEOUT_MS: press_timeout_ff  <= csr_wdata[TIME_W-1:0];
            CSR_FAST_WINDOW_MS:   fast_window_ff    <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Step, clamp/wrap and load logic
   always_comb begin
      press_open_in  = press_open_ff;
      press_start_in = press_start_ff;
      captured_b_in  = captured_b_ff;
      last_step_in   = last_step_ff;
      position_in    = position_ff;
      rsp_in         = '0;

      // unsigned differences so the timestamp wraps cleanly
      press_elapsed = req_ff.now_ms - press_start_ff;
      step_elapsed  = req_ff.now_ms - last_step_ff;

      // fast step never below the normal step
      if ((step_elapsed < fast_window_ff) && (fast_step_size_ff > step_size_ff))
         inc = fast_step_size_ff;
      else
         inc = step_size_ff;

      pos_ext  = SUM_W'(position_ff);
      inc_ext  = SUM_W'({1'b0, inc});
      lmin_ext = SUM_W'(min_position_ff);
      lmax_ext = SUM_W'(max_position_ff);
      load_ext = SUM_W'(req_ff.load_value);
      sum      = captured_b_ff ? (pos_ext - inc_ext) : (pos_ext + inc_ext);

      // upper limit first, then lower limit on the result
      if (sum > lmax_ext)
         upper_fix = wrap_enable_ff ? lmin_ext : lmax_ext;
      else
         upper_fix = sum;
      if (upper_fix < lmin_ext)
         lower_fix = wrap_enable_ff ? lmax_ext : lmin_ext;
      else
         lower_fix = upper_fix;

      load_in_range = (load_ext >= lmin_ext) && (load_ext <= lmax_ext);

      if (req_ff.req_type == REQ_LOAD) begin
         if (load_in_range) begin
            position_in          = req_ff.load_value;
            rsp_in.load_accepted = 1'b1;
         end
      end else if (!req_ff.chan_a) begin
         // falling A opens a press unless one is still live
         if (!press_open_ff || (press_elapsed > press_timeout_ff)) begin
            press_open_in  = 1'b1;
            press_start_in = req_ff.now_ms;
            captured_b_in  = req_ff.chan_b;
         end
      end else if (press_open_ff) begin
         // rising A closes the press; steps only within the timeout
         if (press_elapsed < press_timeout_ff) begin
            last_step_in = req_ff.now_ms;
            position_in  = lower_fix[POS_W-1:0];
            rsp_in.moved = 1'b1;
         end
         press_open_in = 1'b0;
      end

      rsp_in.position = position_in;
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff <= req_unpacked;
      end
   end

   // State and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         press_open_ff  <= 1'b0;
         press_start_ff <= '0;
         captured_b_ff  <= 1'b0;
         last_step_ff   <= '0;
         position_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            press_open_ff  <= press_open_in;
            press_start_ff <= press_start_in;
            captured_b_ff  <= captured_b_in;
            last_step_ff   <= last_step_in;
            position_ff    <= position_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // A response never reports both a load and a step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.moved && rsp_ff.load_accepted))
      else $error("response marks both load_accepted and moved");

   // A held request is not dropped while the response side stalls
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> req_valid_ff)
      else $error("stalled request lost");

   // Any rising A event leaves the press closed
   assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.req_type == REQ_CHAN_A_EVENT && req_ff.chan_a) |=> !press_open_ff)
      else $error("press still open after rising A");

   // The response register shows the position that was committed with it
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff.position == position_ff))
      else $error("response position differs from stored position");

endmodule

`default_nettype wire
